// File: src/single_button_dimmer_macros.svh
// Assertion macros for the single button dimmer.
// Define NO_ASSERTIONS to compile them away.
`ifndef SINGLE_BUTTON_DIMMER_MACROS_SVH
`define SINGLE_BUTTON_DIMMER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property holds at every edge outside reset.
`define SBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition never holds outside reset.
`define SBD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SBD_ASSERT(label, prop, msg)
`define SBD_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: src/sbd_pkg.sv
`default_nettype none

package sbd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned StepW  = 6;
  localparam int unsigned LevelW = 7;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned IdxW   = 3;

  localparam logic [LevelW-1:0] LevelMax = 7'd100;

  // level*255/100 as level*round_up(255*2^19/100) >> 19, exact for level <= 100
  localparam logic [20:0] DutyRecip = 21'd1336935;
  localparam int unsigned DutyShift = 19;

  typedef enum logic [IdxW-1:0] {
    REG_LONG_PRESS    = 3'd0,
    REG_RAMP_INTERVAL = 3'd1,
    REG_MIN_CLICK     = 3'd2,
    REG_RAMP_STEP     = 3'd3,
    REG_ON_LEVEL      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [MsW-1:0]    long_press_ms;
    logic [MsW-1:0]    ramp_interval_ms;
    logic [MsW-1:0]    min_click_ms;
    logic [StepW-1:0]  ramp_step;
    logic [LevelW-1:0] on_level_pct;
  } cfg_t;

  typedef struct packed {
    logic                     prev_pressed;
    logic [TimeW-1:0]         press_start;
    logic                     long_hold_seen;
    logic signed [LevelW-1:0] ramp_dir;
    logic [TimeW-1:0]         last_step_time;
    logic [LevelW-1:0]        level;
    logic                     lamp_on;
    logic [DutyW-1:0]         duty;
  } state_t;

  function automatic logic [DutyW-1:0] duty_of(input logic [LevelW-1:0] lv);
    logic [27:0] prod;
    prod = 28'(lv) * 28'(DutyRecip);
    return prod[DutyShift +: DutyW];
  endfunction

endpackage

`default_nettype wire

// File: src/sbd_update.sv
`default_nettype none

module sbd_update (
  input  sbd_pkg::cfg_t                  cfg,
  input  sbd_pkg::state_t                cur,
  input  logic                           pressed,
  input  logic [sbd_pkg::TimeW-1:0]      now_ms,
  output sbd_pkg::state_t                nxt
);

  logic                          rise;
  logic                          hold;
  logic                          fall;
  logic [sbd_pkg::TimeW-1:0]     held_ms;
  logic [sbd_pkg::TimeW-1:0]     since_step;
  logic                          long_hold;
  logic                          do_step;
  logic                          click;
  logic signed [8:0]             stepped;
  logic [sbd_pkg::LevelW-1:0]    on_level_sat;
  logic [sbd_pkg::LevelW-1:0]    level_new;
  logic                          lamp_new;

  assign rise = pressed & ~cur.prev_pressed;
  assign hold = pressed & cur.prev_pressed;
  assign fall = ~pressed & cur.prev_pressed;

  assign held_ms    = now_ms - cur.press_start;
  assign since_step = now_ms - cur.last_step_time;

  assign long_hold = hold && (held_ms > {16'd0, cfg.long_press_ms});
  assign do_step   = long_hold && (since_step > {16'd0, cfg.ramp_interval_ms});
  assign click     = fall && !cur.long_hold_seen && (held_ms > {16'd0, cfg.min_click_ms});

  assign stepped = $signed({2'b00, cur.level}) + 9'(cur.ramp_dir);

  assign on_level_sat = (cfg.on_level_pct > sbd_pkg::LevelMax) ? sbd_pkg::LevelMax
                                                               : cfg.on_level_pct;

  always_comb begin
    nxt       = cur;
    level_new = cur.level;
    lamp_new  = cur.lamp_on;

    nxt.prev_pressed = pressed;

    if (rise) begin
      nxt.press_start    = now_ms;
      nxt.long_hold_seen = 1'b0;
    end

    if (long_hold) begin
      nxt.long_hold_seen = 1'b1;
      lamp_new           = 1'b1;
    end

    if (do_step) begin
      // clamp at the ends and reverse with the configured step size
      if (stepped >= $signed({2'b00, sbd_pkg::LevelMax})) begin
        level_new    = sbd_pkg::LevelMax;
        nxt.ramp_dir = -$signed({1'b0, cfg.ramp_step});
      end else if (stepped <= 9'sd0) begin
        level_new    = '0;
        nxt.ramp_dir = $signed({1'b0, cfg.ramp_step});
      end else begin
        level_new = stepped[sbd_pkg::LevelW-1:0];
      end
      nxt.last_step_time = now_ms;
    end

    if (click) begin
      lamp_new = ~cur.lamp_on;
      if (!cur.lamp_on && cur.level == '0) begin
        level_new = on_level_sat;
      end
    end

    nxt.level   = level_new;
    nxt.lamp_on = lamp_new;

    if (do_step || (click && lamp_new)) begin
      nxt.duty = sbd_pkg::duty_of(level_new);
    end else if (click) begin
      nxt.duty = '0;
    end
  end

endmodule

`default_nettype wire

// File: src/single_button_dimmer.sv
// Single button dimmer: takes timestamped samples of one button and gives, for
// every sample, the lamp state, the brightness level in percent and the drive duty.
// Input stream: in_tdata carries the button level and its millisecond timestamp.
// Output stream: one transaction per input transaction, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while no sample is in flight. Indexes above the register list are
// dropped.
// Path: a sample waits in the input register; the state update and the result
// register load happen on the edge at which it advances, so the result is then on
// out_tdata and leaves at the first edge with out_tready high.
// Throughput: one sample per cycle while out_tready is high; the state feedback is a
// single add, clamp and constant multiply, so only a stall on the output lowers the rate.
// Stall: while out_tready is low the result is held; one more sample is taken into
// the input register, then in_tready drops until the result leaves.
// Reset (rst_n low, synchronous): lamp off, level 0, duty 0, ramp direction +1,
// registers back to 400, 15, 50, 5 and 100.
`default_nettype none

module single_button_dimmer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] button_pressed, [32:1] now_ms, [39:33] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] led_on, [7:1] level_pct, [15:8] pwm_duty
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sbd_pkg::cfg_t   cfg_r;
  sbd_pkg::state_t state_r;
  sbd_pkg::state_t state_nxt;

  logic                        s1_valid_r;
  logic                        s1_pressed_r;
  logic [sbd_pkg::TimeW-1:0]   s1_now_r;
  logic                        advance;

  logic        out_valid_r;
  logic [15:0] out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms    <= 16'd400;
      cfg_r.ramp_interval_ms <= 16'd15;
      cfg_r.min_click_ms     <= 16'd50;
      cfg_r.ramp_step        <= 6'd5;
      cfg_r.on_level_pct     <= 7'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sbd_pkg::reg_idx_t'(cfg_index))
        sbd_pkg::REG_LONG_PRESS:    cfg_r.long_press_ms    <= cfg_data;
        sbd_pkg::REG_RAMP_INTERVAL: cfg_r.ramp_interval_ms <= cfg_data;
        sbd_pkg::REG_MIN_CLICK:     cfg_r.min_click_ms     <= cfg_data;
        sbd_pkg::REG_RAMP_STEP:     cfg_r.ramp_step        <= cfg_data[sbd_pkg::StepW-1:0];
        sbd_pkg::REG_ON_LEVEL:      cfg_r.on_level_pct     <= cfg_data[sbd_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  // the input register moves on whenever the result register can take its result
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pressed_r <= in_tdata[0];
      s1_now_r     <= in_tdata[32:1];
    end
  end

  sbd_update u_update (
    .cfg     (cfg_r),
    .cur     (state_r),
    .pressed (s1_pressed_r),
    .now_ms  (s1_now_r),
    .nxt     (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prev_pressed   <= 1'b0;
      state_r.press_start    <= '0;
      state_r.long_hold_seen <= 1'b0;
      state_r.ramp_dir       <= 7'sd1;
      state_r.last_step_time <= '0;
      state_r.level          <= '0;
      state_r.lamp_on        <= 1'b0;
      state_r.duty           <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {state_nxt.duty, state_nxt.level, state_nxt.lamp_on};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "single_button_dimmer_macros.svh"

  `SBD_ASSERT_NEVER(a_level_range, state_r.level > sbd_pkg::LevelMax, "level above 100")
  `SBD_ASSERT(a_off_means_zero_duty, !state_r.lamp_on |-> state_r.duty == '0, "duty while off")
  `SBD_ASSERT(a_s1_held, s1_valid_r && !advance |=> s1_valid_r && $stable(s1_now_r), "sample lost")
  `SBD_ASSERT(a_state_only_on_advance, !advance |=> $stable(state_r.level), "level moved idle")

endmodule

`default_nettype wire
